### design/snts_pkg.sv
// shared types, constants and the power-of-ten table for the token sampler
package snts_pkg;

  localparam int unsigned MANT_W = 60;
  localparam int unsigned EXP_W  = 9;
  localparam int unsigned VAL_W  = 48;
  localparam int unsigned DIV_W  = 76;

  localparam logic [MANT_W-1:0] MANT_LIMIT = 60'd100000000000000000;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_OUTLIER = 2'd2
  } tok_status_t;

  localparam logic [1:0] CFG_AUTO_RANGE  = 2'd0;
  localparam logic [1:0] CFG_MANUAL_LOW  = 2'd1;
  localparam logic [1:0] CFG_MANUAL_HIGH = 2'd2;

  typedef struct packed {
    logic                     bad;
    logic                     neg;
    logic [MANT_W-1:0]        mant;
    logic signed [EXP_W-1:0]  expo;
  } tok_desc_t;

  typedef struct packed {
    logic                     auto_range;
    logic signed [VAL_W-1:0]  manual_low;
    logic signed [VAL_W-1:0]  manual_high;
  } range_cfg_t;

  function automatic logic [MANT_W-1:0] pow10(input logic [4:0] k);
    logic [MANT_W-1:0] p;
    p = 60'd1;
    unique case (k)
      5'd0:  p = 60'd1;
      5'd1:  p = 60'd10;
      5'd2:  p = 60'd100;
      5'd3:  p = 60'd1000;
      5'd4:  p = 60'd10000;
      5'd5:  p = 60'd100000;
      5'd6:  p = 60'd1000000;
      5'd7:  p = 60'd10000000;
      5'd8:  p = 60'd100000000;
      5'd9:  p = 60'd1000000000;
      5'd10: p = 60'd10000000000;
      5'd11: p = 60'd100000000000;
      5'd12: p = 60'd1000000000000;
      5'd13: p = 60'd10000000000000;
      5'd14: p = 60'd100000000000000;
      5'd15: p = 60'd1000000000000000;
      5'd16: p = 60'd10000000000000000;
      5'd17: p = 60'd100000000000000000;
      5'd18: p = 60'd1000000000000000000;
      default: p = 60'd1;
    endcase
    return p;
  endfunction

endpackage

### design/snts_ram.sv
// generic simple dual-port ram with registered read
module snts_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

### design/snts_fifo.sv
// two-entry queue of finished token descriptors
module snts_fifo import snts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tok_desc_t push_data,
  input  logic      pop,
  output tok_desc_t pop_data,
  output logic      full,
  output logic      empty
);
  tok_desc_t  ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) begin
        wp_r <= ~wp_r;
      end
      if (pop && !empty) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
endmodule

### design/snts_front.sv
// character front end: builds the token and hands a descriptor to the queue
module snts_front import snts_pkg::*; #(
  parameter int unsigned TOKEN_CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  logic [7:0] rx_byte,
  output logic      desc_push,
  output tok_desc_t desc
);
  localparam int unsigned CW = $clog2(TOKEN_CAPACITY);

  logic [CW-1:0]       chars_r;
  logic                inv_r, dot_r, dig_r, neg_r, expf_r, stop_r;
  logic [MANT_W-1:0]   mant_r;
  logic signed [7:0]   ds_r;
  logic [6:0]          ex_r;

  logic        is_digit, is_sep, is_legal;
  logic [3:0]  dval;
  logic [MANT_W-1:0] mant_mac;
  logic [10:0] ex_mac;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_sep   = (rx_byte == CH_CR) || (rx_byte == CH_LF) || (rx_byte == CH_SPACE) ||
                    (rx_byte == CH_TAB) || (rx_byte == CH_COMMA);
  assign is_legal = is_digit || (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS) ||
                    (rx_byte == CH_DOT) || (rx_byte == CH_E_UP) || (rx_byte == CH_E_LO);
  assign dval     = 4'(rx_byte - CH_ZERO);
  assign mant_mac = (mant_r << 3) + (mant_r << 1) + MANT_W'(dval);
  assign ex_mac   = ({4'b0, ex_r} << 3) + ({4'b0, ex_r} << 1) + 11'(dval);

  assign desc_push = take && is_sep && (chars_r != '0);
  assign desc.bad  = inv_r || !dig_r;
  assign desc.neg  = neg_r;
  assign desc.mant = mant_r;
  assign desc.expo = EXP_W'(ds_r) + $signed({2'b00, ex_r});

  always_ff @(posedge clk) begin
    if (!rst_n || (take && (is_sep || !is_legal))) begin
      chars_r <= '0;
      inv_r   <= 1'b0;
      dot_r   <= 1'b0;
      dig_r   <= 1'b0;
      neg_r   <= 1'b0;
      expf_r  <= 1'b0;
      stop_r  <= 1'b0;
      mant_r  <= '0;
      ds_r    <= '0;
      ex_r    <= '0;
    end else if (take && (chars_r < CW'(TOKEN_CAPACITY - 1))) begin
      chars_r <= chars_r + 1'b1;
      if (is_digit) begin
        dig_r <= 1'b1;
        if (!(inv_r || stop_r)) begin
          priority if (expf_r) begin
            ex_r <= (ex_mac > 11'd127) ? 7'd127 : ex_mac[6:0];
          end else if (dot_r) begin
            if ((ds_r > -8'sd18) && (mant_r < MANT_LIMIT)) begin
              mant_r <= mant_mac;
              ds_r   <= ds_r - 8'sd1;
            end
          end else if (mant_r < MANT_LIMIT) begin
            mant_r <= mant_mac;
          end else if (ds_r < 8'sd127) begin
            ds_r <= ds_r + 8'sd1;
          end
        end
      end else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
        if (chars_r != '0) begin
          inv_r <= 1'b1;
        end else if (rx_byte == CH_MINUS) begin
          neg_r <= 1'b1;
        end
      end else if (rx_byte == CH_DOT) begin
        if (dot_r) begin
          inv_r <= 1'b1;
        end else begin
          dot_r <= 1'b1;
          if (expf_r) begin
            stop_r <= 1'b1;
          end
        end
      end else if (!stop_r) begin
        // exponent marker
        priority if (expf_r) begin
          stop_r <= 1'b1;
        end else if (dig_r) begin
          expf_r <= 1'b1;
        end else begin
          stop_r <= 1'b1;
        end
      end
    end
  end
endmodule

### design/snts_back.sv
// back end: conversion, outlier test, sample ring and result register
module snts_back import snts_pkg::*; #(
  parameter int unsigned WINDOW_SAMPLES = 320
) (
  input  logic               clk,
  input  logic               rst_n,
  input  range_cfg_t         cfg,
  input  logic               q_empty,
  input  tok_desc_t          q_data,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_valid,
  output logic [VAL_W-1:0]   out_value,
  output logic [1:0]         out_status
);
  localparam int unsigned AW = $clog2(WINDOW_SAMPLES);
  localparam int unsigned FW = $clog2(WINDOW_SAMPLES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_CONV, S_SIGN, S_SCAN, S_WIDEN, S_PAD_SER, S_PAD_FIX,
    S_SPAN, S_CMP, S_STORE, S_EMIT
  } state_t;

  state_t               st_r;
  logic                 neg_r;
  logic [DIV_W-1:0]     acc_r;
  logic [MANT_W-1:0]    rem_r, den_r;
  logic [7:0]           cnt_r;
  logic [VAL_W:0]       mag_r;
  logic [VAL_W-1:0]     val_r;
  tok_status_t          res_stat_r;
  logic signed [63:0]   lo_r, hi_r, span_r, dist_r;
  logic [63:0]          pad_x_r, pad_q_r;
  logic [2:0]           pad_step_r;
  logic [FW-1:0]        scan_idx_r, fill_r;
  logic                 scan_pend_r, scan_first_r, have_r;
  logic [AW-1:0]        widx_r;
  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_value_r;
  tok_status_t          out_stat_r;

  logic [VAL_W-1:0]   ram_rdata;
  logic               ram_we;
  logic [MANT_W:0]    rem2;
  logic               div_ge;
  logic [MANT_W-1:0]  m_cur;
  logic signed [63:0] samp, val_ext, absd, span20;
  logic [63:0]        pad_rem;
  logic [4:0]         kdig;
  logic signed [EXP_W-1:0] nexp;

  snts_ram #(.WIDTH(VAL_W), .DEPTH(WINDOW_SAMPLES)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_r),
    .wdata (val_r),
    .raddr (scan_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign ram_we   = (st_r == S_STORE);
  assign q_pop    = (st_r == S_IDLE) && !q_empty;
  assign rem2     = {rem_r, acc_r[DIV_W-1]};
  assign div_ge   = rem2 >= {1'b0, den_r};
  assign m_cur    = acc_r[MANT_W-1:0];
  assign samp     = {{16{ram_rdata[VAL_W-1]}}, ram_rdata};
  assign val_ext  = {{16{val_r[VAL_W-1]}}, val_r};
  assign absd     = (dist_r < 0) ? -dist_r : dist_r;
  assign span20   = (span_r <<< 4) + (span_r <<< 2);
  assign pad_rem  = pad_x_r - ((pad_q_r << 4) + (pad_q_r << 2));
  assign nexp     = -q_data.expo;
  assign kdig     = (nexp > 9'sd18) ? 5'd18 : nexp[4:0];

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      widx_r      <= '0;
      fill_r      <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      scan_pend_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r && (st_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            neg_r <= q_data.neg;
            if (q_data.bad) begin
              val_r      <= '0;
              res_stat_r <= ST_INVALID;
              st_r       <= S_EMIT;
            end else if (q_data.mant == '0) begin
              mag_r <= '0;
              st_r  <= S_SIGN;
            end else if (!q_data.expo[EXP_W-1]) begin
              acc_r <= DIV_W'(q_data.mant);
              cnt_r <= q_data.expo[7:0];
              st_r  <= S_MUL;
            end else begin
              acc_r     <= {q_data.mant, 16'b0};
              rem_r     <= '0;
              den_r     <= pow10(kdig);
              cnt_r     <= 8'(DIV_W);
              st_r      <= S_DIV;
            end
          end
        end
        S_MUL: begin
          // scale by ten until the exponent runs out or it overflows
          if (m_cur > MANT_W'(64'h1_0000_0000)) begin
            mag_r <= {1'b1, {VAL_W{1'b0}}};
            st_r  <= S_SIGN;
          end else if (cnt_r == 8'd0) begin
            mag_r <= {m_cur[32:0], 16'b0};
            st_r  <= S_SIGN;
          end else begin
            acc_r <= DIV_W'((m_cur << 3) + (m_cur << 1));
            cnt_r <= cnt_r - 8'd1;
          end
        end
        S_DIV: begin
          if (cnt_r == 8'd0) begin
            st_r <= S_CONV;
          end else begin
            acc_r <= {acc_r[DIV_W-2:0], div_ge};
            rem_r <= div_ge ? MANT_W'(rem2 - {1'b0, den_r}) : rem2[MANT_W-1:0];
            cnt_r <= cnt_r - 8'd1;
          end
        end
        S_CONV: begin
          if (|acc_r[DIV_W-1:VAL_W]) begin
            mag_r <= {1'b1, {VAL_W{1'b0}}};
          end else begin
            mag_r <= {1'b0, acc_r[VAL_W-1:0]} +
                     (VAL_W+1)'(({rem_r, 1'b0} >= {1'b0, den_r}) ? 1 : 0);
          end
          st_r <= S_SIGN;
        end
        S_SIGN: begin
          if (neg_r) begin
            val_r <= (mag_r > (VAL_W+1)'(49'h0800000000000)) ? {1'b1, {(VAL_W-1){1'b0}}}
                                                       : VAL_W'(-mag_r);
          end else begin
            val_r <= (mag_r > (VAL_W+1)'(49'h07fffffffffff)) ? {1'b0, {(VAL_W-1){1'b1}}}
                                                       : mag_r[VAL_W-1:0];
          end
          priority if (!have_r || (fill_r < FW'(2))) begin
            st_r <= S_STORE;
          end else if (!cfg.auto_range) begin
            lo_r <= 64'(cfg.manual_low);
            hi_r <= 64'(cfg.manual_high);
            st_r <= S_SPAN;
          end else begin
            scan_idx_r   <= '0;
            scan_pend_r  <= 1'b0;
            scan_first_r <= 1'b1;
            st_r         <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one ring read a cycle, data folded in on the cycle after
          if (scan_idx_r < fill_r) begin
            scan_idx_r  <= scan_idx_r + 1'b1;
            scan_pend_r <= 1'b1;
          end else begin
            scan_pend_r <= 1'b0;
            if (!scan_pend_r) begin
              st_r <= S_WIDEN;
            end
          end
          if (scan_pend_r) begin
            scan_first_r <= 1'b0;
            if (scan_first_r || (samp < lo_r)) begin
              lo_r <= samp;
            end
            if (scan_first_r || (samp > hi_r)) begin
              hi_r <= samp;
            end
          end
        end
        S_WIDEN: begin
          // pad is (span + 10) / 20, taken on the widened span
          pad_x_r <= $unsigned(hi_r - lo_r + ((lo_r == hi_r) ? 64'sd131082 : 64'sd10));
          if (lo_r == hi_r) begin
            lo_r <= lo_r - 64'sd65536;
            hi_r <= hi_r + 64'sd65536;
          end
          pad_step_r <= 3'd0;
          st_r       <= S_PAD_SER;
        end
        S_PAD_SER: begin
          // x * 3/64 * (1 + 1/16)(1 + 1/256)... approaches x / 20 from below
          unique case (pad_step_r)
            3'd0:    pad_q_r <= (pad_x_r >> 5) + (pad_x_r >> 6);
            3'd1:    pad_q_r <= pad_q_r + (pad_q_r >> 4);
            3'd2:    pad_q_r <= pad_q_r + (pad_q_r >> 8);
            3'd3:    pad_q_r <= pad_q_r + (pad_q_r >> 16);
            default: pad_q_r <= pad_q_r + (pad_q_r >> 32);
          endcase
          pad_step_r <= pad_step_r + 3'd1;
          if (pad_step_r == 3'd4) begin
            st_r <= S_PAD_FIX;
          end
        end
        S_PAD_FIX: begin
          // estimate is a few short at most, step it up to the exact quotient
          if (pad_rem >= 64'd20) begin
            pad_q_r <= pad_q_r + 64'd1;
          end else begin
            lo_r <= lo_r - $signed(pad_q_r);
            hi_r <= hi_r + $signed(pad_q_r);
            st_r <= S_SPAN;
          end
        end
        S_SPAN: begin
          span_r <= hi_r - lo_r;
          dist_r <= (val_ext <<< 1) - (lo_r + hi_r);
          st_r   <= S_CMP;
        end
        S_CMP: begin
          if ((span_r > 0) && (absd > span20)) begin
            res_stat_r <= ST_OUTLIER;
            st_r       <= S_EMIT;
          end else begin
            st_r <= S_STORE;
          end
        end
        S_STORE: begin
          widx_r     <= (widx_r == AW'(WINDOW_SAMPLES - 1)) ? '0 : widx_r + 1'b1;
          if (fill_r < FW'(WINDOW_SAMPLES)) begin
            fill_r <= fill_r + 1'b1;
          end
          have_r     <= 1'b1;
          res_stat_r <= ST_OK;
          st_r       <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_pop) begin
            out_valid_r <= 1'b1;
            out_value_r <= val_r;
            out_stat_r  <= res_stat_r;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WINDOW_SAMPLES))
    else $error("ring fill beyond window");
  a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
    widx_r < AW'(WINDOW_SAMPLES))
    else $error("ring index out of range");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stat_r == ST_INVALID) |-> (out_value_r == '0))
    else $error("invalid word carries a value");
  a_store_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_STORE) |=> have_r && (fill_r != '0))
    else $error("store did not mark data");
endmodule

### design/serial_number_token_sampler_unit.sv
// top level of the serial number token sampler
// the back end works on one token at a time and shows its word only after it is done
// with it: a fraction goes through the bit-serial divider, and in auto range a scan over
// the ring and the padding series follow
// the front end takes one byte a cycle until its two-word token queue fills
// reset is synchronous, active low; the ring needs no clearing pass and uses only written slots
module serial_number_token_sampler_unit import snts_pkg::*; #(
  parameter int unsigned WINDOW_SAMPLES = 320,
  parameter int unsigned TOKEN_CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [VAL_W-1:0]   out_sample_value,
  output logic [1:0]         out_token_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [VAL_W-1:0]   cfg_wdata
);
  // configuration registers
  range_cfg_t cfg_r;

  // front to back queue
  tok_desc_t  desc, q_data;
  logic       desc_push, q_full, q_empty, q_pop, take, out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_range  <= 1'b1;
      cfg_r.manual_low  <= '0;
      cfg_r.manual_high <= 48'sd6553600;   // 100.0
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTO_RANGE:  cfg_r.auto_range  <= cfg_wdata[0];
        CFG_MANUAL_LOW:  cfg_r.manual_low  <= cfg_wdata;
        CFG_MANUAL_HIGH: cfg_r.manual_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hold off bytes only while the token queue is full
  assign in_full = q_full;
  assign take    = in_push && !q_full;

  snts_front #(.TOKEN_CAPACITY(TOKEN_CAPACITY)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .desc_push (desc_push),
    .desc      (desc)
  );

  snts_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_data (desc),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  snts_back #(.WINDOW_SAMPLES(WINDOW_SAMPLES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_pop    (out_pop),
    .out_valid  (out_valid),
    .out_value  (out_sample_value),
    .out_status (out_token_status)
  );

  // result register shows the oldest word
  assign out_empty = !out_valid;
endmodule

### tb/sv/serial_number_token_sampler_unit_tb.sv
// testbench for the serial number token sampler: byte stream in, checked token words out
`timescale 1ns / 1ps

module serial_number_token_sampler_unit_tb;
  import snts_pkg::*;

  localparam int unsigned WINDOW     = 320;
  localparam int unsigned TOKEN_CAP  = 32;
  localparam int          SETTLE     = 600;      // worst token latency plus margin
  localparam longint      CYCLE_CAP  = 4000000;
  localparam int          RANDOM_BYTES = 1230;
  localparam longint unsigned MANT_CAP = 64'd100000000000000000;

  typedef struct {
    logic [VAL_W-1:0] value;
    tok_status_t      status;
  } token_word_t;

  logic             clk;
  logic             rst_n;
  logic             in_push;
  logic             in_full;
  logic [7:0]       in_rx_byte;
  logic             out_empty;
  logic             out_pop;
  logic [VAL_W-1:0] out_sample_value;
  logic [1:0]       out_token_status;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [VAL_W-1:0] cfg_wdata;

  serial_number_token_sampler_unit #(
    .WINDOW_SAMPLES(WINDOW),
    .TOKEN_CAPACITY(TOKEN_CAP)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_rx_byte(in_rx_byte),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_sample_value(out_sample_value), .out_token_status(out_token_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // bytes waiting for the driver, and words the sampler still owes us
  logic [7:0]  byte_backlog[$];
  token_word_t owed_words[$];
  int          mismatches = 0;
  longint      cycles = 0;

  // shadow copy of the sampler state
  longint          ring_copy[WINDOW];
  int              ring_wr = 0;
  int              ring_cnt = 0;
  bit              ring_live = 0;
  int              tok_len = 0;
  bit              f_bad = 0, f_dot = 0, f_digit = 0, f_neg = 0, f_exp = 0, f_stop = 0;
  longint unsigned tok_mant = 0;
  int              tok_shift = 0;
  int              tok_exp = 0;
  bit              rng_auto = 1;
  longint          rng_low = 0;
  longint          rng_high = 6553600;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void drop_token();
    tok_len = 0;
    {f_bad, f_dot, f_digit, f_neg, f_exp, f_stop} = '0;
    tok_mant = 0;
    tok_shift = 0;
    tok_exp = 0;
  endfunction

  // decimal mantissa and power of ten to saturated Q31.16, ties away from zero
  function automatic longint to_fixed();
    int              e;
    int              k;
    longint unsigned m, mag, d, q, r;
    bit              sat;
    e = tok_shift + tok_exp;
    m = tok_mant;
    sat = 0;
    if (m == 0) begin
      mag = 0;
    end else if (e >= 0) begin
      for (int i = 0; i < e; i++) begin
        if (m > (64'd1 << 32)) begin
          sat = 1;
          break;
        end
        m = m * 10;
      end
      if (m > (64'd1 << 32)) sat = 1;
      mag = sat ? (64'd1 << 48) : (m << 16);
    end else begin
      k = (-e > 18) ? 18 : -e;
      d = 1;
      for (int i = 0; i < k; i++) d = d * 10;
      q = m / d;
      r = m % d;
      if (q >= (64'd1 << 32)) begin
        mag = 64'd1 << 48;
      end else begin
        mag = q;
        // sixteen fraction bits by long division
        for (int i = 0; i < 16; i++) begin
          r = r << 1;
          mag = mag << 1;
          if (r >= d) begin
            r = r - d;
            mag = mag | 1;
          end
        end
        if ((r << 1) >= d) mag++;
      end
    end
    if (f_neg) begin
      if (mag > (64'd1 << 47)) mag = 64'd1 << 47;
      return -longint'(mag);
    end
    if (mag > (64'd1 << 47) - 1) mag = (64'd1 << 47) - 1;
    return longint'(mag);
  endfunction

  function automatic bit far_out(input longint v);
    longint lo, hi, span, dev, pad;
    if (!ring_live || ring_cnt < 2) return 0;
    if (!rng_auto) begin
      lo = rng_low;
      hi = rng_high;
    end else begin
      lo = ring_copy[0];
      hi = ring_copy[0];
      for (int i = 1; i < ring_cnt; i++) begin
        if (ring_copy[i] < lo) lo = ring_copy[i];
        if (ring_copy[i] > hi) hi = ring_copy[i];
      end
      // flat window gets widened by 1.0 each way
      if (lo == hi) begin
        lo -= 65536;
        hi += 65536;
      end
      pad = ((hi - lo) * 5 + 50) / 100;
      lo -= pad;
      hi += pad;
    end
    span = hi - lo;
    if (span <= 0) return 0;
    dev = 2 * v - (lo + hi);
    if (dev < 0) dev = -dev;
    return dev > 20 * span;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    int pos;
    pos = tok_len;
    if (pos >= TOKEN_CAP - 1) return;   // beyond capacity legal chars are ignored
    tok_len = pos + 1;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      f_digit = 1;
      if (f_bad || f_stop) return;
      if (f_exp) begin
        tok_exp = tok_exp * 10 + (c - CH_ZERO);
        if (tok_exp > 127) tok_exp = 127;
      end else if (f_dot) begin
        if (tok_shift > -18 && tok_mant < MANT_CAP) begin
          tok_mant = tok_mant * 10 + (c - CH_ZERO);
          tok_shift--;
        end
      end else if (tok_mant < MANT_CAP) begin
        tok_mant = tok_mant * 10 + (c - CH_ZERO);
      end else if (tok_shift < 127) begin
        tok_shift++;
      end
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      if (pos != 0) f_bad = 1;
      else if (c == CH_MINUS) f_neg = 1;
    end else if (c == CH_DOT) begin
      if (f_dot) begin
        f_bad = 1;
      end else begin
        f_dot = 1;
        if (f_exp) f_stop = 1;
      end
    end else begin
      // e or E
      if (f_stop) return;
      if (f_exp) f_stop = 1;
      else if (f_digit) f_exp = 1;
      else f_stop = 1;
    end
  endfunction

  // advance the shadow state by one accepted byte, queueing any word it causes
  function automatic void sample_byte(input logic [7:0] c);
    token_word_t w;
    longint      v;
    bit          sep, legal;
    sep = (c == CH_CR || c == CH_LF || c == CH_SPACE || c == CH_TAB || c == CH_COMMA);
    if (!sep) begin
      legal = (c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_PLUS ||
              c == CH_DOT || c == CH_E_UP || c == CH_E_LO;
      if (legal) take_char(c);
      else drop_token();
      return;
    end
    if (tok_len == 0) return;
    if (f_bad || !f_digit) begin
      v = 0;
      w.status = ST_INVALID;
    end else begin
      v = to_fixed();
      if (far_out(v)) begin
        w.status = ST_OUTLIER;
      end else begin
        w.status = ST_OK;
        ring_copy[ring_wr] = v;
        ring_wr = (ring_wr + 1 >= WINDOW) ? 0 : ring_wr + 1;
        if (ring_cnt < WINDOW) ring_cnt++;
        ring_live = 1;
      end
    end
    w.value = v[VAL_W-1:0];
    owed_words.push_back(w);
    drop_token();
  endfunction

  // driver: one byte per push, random gap after each, with calm stretches
  int unsigned send_gap = 0;
  bit          send_calm = 0;
  always @(posedge clk) begin
    logic [7:0] nb;
    bit         push_next;
    if (!rst_n) begin
      in_push <= 1'b0;
      in_rx_byte <= '0;
    end else begin
      push_next = in_push;
      nb = in_rx_byte;
      if (in_push && !in_full) begin
        sample_byte(in_rx_byte);
        push_next = 0;
        if ($urandom_range(0, 99) < 2) send_calm = ~send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 4);
      end
      if (!push_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (byte_backlog.size() > 0) begin
          nb = byte_backlog.pop_front();
          push_next = 1;
        end
      end
      in_push <= push_next;
      in_rx_byte <= nb;
    end
  end

  // monitor: compare each popped word with the oldest owed one, stall at random
  int unsigned pop_stall = 0;
  bit          pop_calm = 0;
  always @(posedge clk) begin
    token_word_t w;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (owed_words.size() == 0) begin
          report($sformatf("unexpected word value %h status %0d",
                           out_sample_value, out_token_status));
        end else begin
          w = owed_words.pop_front();
          if (out_sample_value !== w.value)
            report($sformatf("value %h, wanted %h", out_sample_value, w.value));
          if (out_token_status !== w.status)
            report($sformatf("status %0d, wanted %0d", out_token_status, w.status));
        end
        if ($urandom_range(0, 99) < 3) pop_calm = ~pop_calm;
        pop_stall = pop_calm ? 0 : $urandom_range(0, 4);
        out_pop <= (pop_stall == 0);
      end else if (pop_stall > 0) begin
        pop_stall--;
        out_pop <= (pop_stall == 0);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_backlog.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 4))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_SPACE;
      3: return CH_TAB;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] any_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // one random token plus one or two separators; returns bytes queued
  function automatic int queue_token();
    int         n0, r, nd;
    logic [7:0] legal_set[15];
    n0 = byte_backlog.size();
    r = $urandom_range(0, 99);
    legal_set = '{CH_ZERO, 8'h31, 8'h35, 8'h37, CH_NINE, CH_PLUS, CH_MINUS, CH_DOT,
                  CH_DOT, CH_E_UP, CH_E_LO, 8'h32, 8'h34, 8'h38, 8'h33};
    if (r < 75) begin
      // mostly well-formed number with random content
      if ($urandom_range(0, 3) == 0) byte_backlog.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      nd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 3);
      for (int i = 0; i < nd; i++) byte_backlog.push_back(any_digit());
      if ($urandom_range(0, 1) || nd == 0) begin
        byte_backlog.push_back(CH_DOT);
        nd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 5);
        for (int i = 0; i < nd; i++) byte_backlog.push_back(any_digit());
      end
      if ($urandom_range(0, 9) == 0) begin
        byte_backlog.push_back($urandom_range(0, 1) ? CH_E_UP : CH_E_LO);
        nd = $urandom_range(0, 3);
        for (int i = 0; i < nd; i++) byte_backlog.push_back(any_digit());
      end
    end else if (r < 90) begin
      // random sequence of legal characters, mostly malformed
      nd = $urandom_range(1, 10);
      for (int i = 0; i < nd; i++) byte_backlog.push_back(legal_set[$urandom_range(0, 14)]);
    end else begin
      // line noise, any byte value
      nd = $urandom_range(1, 3);
      for (int i = 0; i < nd; i++) byte_backlog.push_back(8'($urandom_range(0, 255)));
    end
    byte_backlog.push_back(pick_sep());
    if ($urandom_range(0, 9) == 0) byte_backlog.push_back(pick_sep());
    return byte_backlog.size() - n0;
  endfunction

  // sender holds off until every owed word has come and the sampler has settled
  task automatic drain();
    do @(posedge clk);
    while (byte_backlog.size() != 0 || in_push || owed_words.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [VAL_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_AUTO_RANGE:  rng_auto = val[0];
      CFG_MANUAL_LOW:  rng_low = longint'(signed'(val));
      CFG_MANUAL_HIGH: rng_high = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic random_phase(input int nbytes);
    int sent;
    sent = 0;
    while (sent < nbytes) sent += queue_token();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_AUTO_RANGE;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, signs, dots, exponents, long and broken tokens
    queue_text("0\n-0 +5,1.5\t-2.5\r.5 5. 1e3 1E2 1e e5 1.2.3 1-2 - ");
    queue_text("999999999999999999999 -99999999999 0.00001 1e5.3 1e2e3 ");
    queue_text("0.0000000000000000000001 1e127 12a34 ,  ");
    queue_text("1234567890123456789012345678901234567890 ");
    queue_text("0.99999999999999999999999 -0.0000076 140737488355327.9 ");
    drain();

    // auto range with the reset setting
    random_phase(RANDOM_BYTES / 3);
    drain();

    // manual band of plus or minus 100.0
    write_reg(CFG_AUTO_RANGE, 48'd0);
    write_reg(CFG_MANUAL_LOW, -48'sd6553600);
    write_reg(CFG_MANUAL_HIGH, 48'd6553600);
    queue_text("5000 -5000 2000 -2000 1e9 ");
    random_phase(RANDOM_BYTES / 6);
    drain();

    // widest manual band, then an inverted one that never rejects
    write_reg(CFG_MANUAL_LOW, {1'b1, {(VAL_W-1){1'b0}}});
    write_reg(CFG_MANUAL_HIGH, {1'b0, {(VAL_W-1){1'b1}}});
    random_phase(RANDOM_BYTES / 6);
    drain();
    write_reg(CFG_MANUAL_LOW, 48'd655360);
    write_reg(CFG_MANUAL_HIGH, -48'sd655360);
    random_phase(RANDOM_BYTES / 6);
    drain();

    // back to the window-derived range
    write_reg(CFG_AUTO_RANGE, 48'd1);
    random_phase(RANDOM_BYTES / 6);
    drain();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
